>>> hw/rtl/ipsm_pkg.sv
// Shared types, operation codes and controller/datapath handshake structs.
package ipsm_pkg;

  localparam int PT_W  = 9;
  localparam int CNT_W = 10;
  localparam int OP_W  = 3;

  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_START     = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_MBR   = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_LIB   = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE_LIB = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_LIB  = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_MBR  = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [PT_W-1:0] point;
    logic            color;
  } ipsm_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PT_W-1:0]  value;
    logic             changed;
    logic             overflow;
    logic             group_color_out;
  } ipsm_out_t;

  typedef struct packed {
    logic sweep;
    logic capture;
    logic exec;
    logic read;
    logic slot;
    logic check;
    logic move;
    logic load;
  } ipsm_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic op_lib;
    logic op_read;
    logic erase_move;
    logic out_free;
  } ipsm_sts_t;

endpackage

>>> hw/rtl/ipsm_datapath.sv
// Datapath: group registers, the three single-port memories and the output register.
module ipsm_datapath
  import ipsm_pkg::*;
#(
  parameter int NUM_POINTS    = 512,
  parameter int MAX_LIBERTIES = 256,
  parameter int MAX_MEMBERS   = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ipsm_in_t  in_data,
  input  ipsm_cmd_t cmd,
  output ipsm_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output ipsm_out_t out_data
);

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int PT_AW  = $clog2(NUM_POINTS);
  localparam int LIB_AW = $clog2(MAX_LIBERTIES);
  localparam int MEM_AW = $clog2(MAX_MEMBERS);
  localparam int LC_W   = $clog2(MAX_LIBERTIES + 1);
  localparam int MC_W   = $clog2(MAX_MEMBERS + 1);
  localparam int PC_W   = $clog2(NUM_POINTS + 1);
  localparam int XW     = max2(max2(max2(PC_W, LC_W), max2(MC_W, CNT_W)), PT_W);

  function automatic logic [CNT_W-1:0] to_cnt(input logic [XW-1:0] v);
    return v[CNT_W-1:0];
  endfunction

  // memories
  logic [PT_W-1:0]   lib_mem [MAX_LIBERTIES];
  logic [LIB_AW-1:0] map_mem [NUM_POINTS];
  logic [PT_W-1:0]   mbr_mem [MAX_MEMBERS];

  logic [PT_W-1:0]   lib_rd_r;
  logic [LIB_AW-1:0] map_rd_r;
  logic [PT_W-1:0]   mbr_rd_r;

  logic              lib_we, map_we, mbr_we;
  logic [LIB_AW-1:0] lib_addr;
  logic [PT_W-1:0]   lib_wd;
  logic [PT_AW-1:0]  map_addr;
  logic [LIB_AW-1:0] map_wd;
  logic [MEM_AW-1:0] mbr_addr;
  logic [PT_W-1:0]   mbr_wd;

  // registers
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [PT_W-1:0]   pt_r, pt_nxt;
  logic              cin_r, cin_nxt;
  logic              color_r, color_nxt;
  logic [LC_W-1:0]   lcount_r, lcount_nxt;
  logic [MC_W-1:0]   mcount_r, mcount_nxt;
  logic [LIB_AW-1:0] slot_r, slot_nxt;
  logic [PT_AW-1:0]  sweep_r, sweep_nxt;
  ipsm_out_t         res_r, res_nxt;
  ipsm_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // derived values
  logic [XW-1:0]     pt_x, lc_x, mc_x, moved_x;
  logic              pt_ok, present, lib_full, mbr_full, out_free;
  logic              erase_move;
  logic [LC_W-1:0]   last, lc_inc;
  logic [MC_W-1:0]   mc_inc;
  logic [LIB_AW-1:0] last_idx, lc_idx;

  assign pt_x     = XW'(pt_r);
  assign lc_x     = XW'(lcount_r);
  assign mc_x     = XW'(mcount_r);
  assign moved_x  = XW'(lib_rd_r);
  assign pt_ok    = pt_x < XW'(NUM_POINTS);
  assign last     = lcount_r - LC_W'(1);
  assign last_idx = last[LIB_AW-1:0];
  assign lc_idx   = lcount_r[LIB_AW-1:0];
  assign lc_inc   = lcount_r + LC_W'(1);
  assign mc_inc   = mcount_r + MC_W'(1);
  assign lib_full = lc_x >= XW'(MAX_LIBERTIES);
  assign mbr_full = mc_x >= XW'(MAX_MEMBERS);
  // a map entry counts only if it points below the count at a slot holding this point
  assign present  = pt_ok && (XW'(slot_r) < lc_x) && (lib_rd_r == pt_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    op_nxt        = op_r;
    pt_nxt        = pt_r;
    cin_nxt       = cin_r;
    color_nxt     = color_r;
    lcount_nxt    = lcount_r;
    mcount_nxt    = mcount_r;
    slot_nxt      = slot_r;
    sweep_nxt     = sweep_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    lib_we        = 1'b0;
    lib_addr      = pt_x[LIB_AW-1:0];
    lib_wd        = pt_r;
    map_we        = 1'b0;
    map_addr      = pt_x[PT_AW-1:0];
    map_wd        = lc_idx;
    mbr_we        = 1'b0;
    mbr_addr      = pt_x[MEM_AW-1:0];
    mbr_wd        = pt_r;
    erase_move    = 1'b0;

    if (cmd.sweep) begin
      map_we    = 1'b1;
      map_addr  = sweep_r;
      map_wd    = '0;
      sweep_nxt = sweep_r + PT_AW'(1);
    end

    if (cmd.capture) begin
      op_nxt  = in_data.operation;
      pt_nxt  = in_data.point;
      cin_nxt = in_data.color;
    end

    if (cmd.exec) begin
      res_nxt = '0;
      case (op_r)
        OP_CLEAR: begin
          lcount_nxt      = '0;
          mcount_nxt      = '0;
          res_nxt.changed = 1'b1;
        end
        OP_START: begin
          lcount_nxt      = '0;
          mcount_nxt      = MC_W'(1);
          color_nxt       = cin_r;
          mbr_we          = 1'b1;
          mbr_addr        = '0;
          res_nxt.count   = CNT_W'(1);
          res_nxt.changed = 1'b1;
        end
        OP_ADD_MBR: begin
          if (mbr_full) begin
            res_nxt.overflow = 1'b1;
          end else begin
            mbr_we          = 1'b1;
            mbr_addr        = mcount_r[MEM_AW-1:0];
            mcount_nxt      = mc_inc;
            res_nxt.count   = to_cnt(XW'(mc_inc));
            res_nxt.changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.read) begin
      if (op_r == OP_READ_LIB && pt_x < lc_x) begin
        res_nxt.value = lib_rd_r;
      end else if (op_r == OP_READ_MBR && pt_x < mc_x) begin
        res_nxt.value = mbr_rd_r;
      end
    end

    if (cmd.slot) begin
      slot_nxt = map_rd_r;
      lib_addr = map_rd_r;
    end

    if (cmd.check) begin
      if (op_r == OP_ADD_LIB) begin
        if (pt_ok && !present) begin
          if (lib_full) begin
            res_nxt.overflow = 1'b1;
          end else begin
            lib_we          = 1'b1;
            lib_addr        = lc_idx;
            map_we          = 1'b1;
            lcount_nxt      = lc_inc;
            res_nxt.count   = to_cnt(XW'(lc_inc));
            res_nxt.changed = 1'b1;
          end
        end
      end else if (present) begin
        // erase: drop the count and fetch the tail entry for the swap
        lcount_nxt      = last;
        lib_addr        = last_idx;
        res_nxt.count   = to_cnt(XW'(last));
        res_nxt.changed = 1'b1;
        erase_move      = slot_r != last_idx;
      end
    end

    if (cmd.move) begin
      lib_we   = 1'b1;
      lib_addr = slot_r;
      lib_wd   = lib_rd_r;
      map_we   = 1'b1;
      map_addr = moved_x[PT_AW-1:0];
      map_wd   = slot_r;
    end

    if (cmd.load && out_free) begin
      out_nxt                 = res_r;
      out_nxt.group_color_out = color_r;
      out_valid_nxt           = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.sweep_last = sweep_r == PT_AW'(NUM_POINTS - 1);
  assign sts.op_lib     = (op_r == OP_ADD_LIB) || (op_r == OP_ERASE_LIB);
  assign sts.op_read    = (op_r == OP_READ_LIB) || (op_r == OP_READ_MBR);
  assign sts.erase_move = erase_move;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (lib_we) begin
      lib_mem[lib_addr] <= lib_wd;
    end
    lib_rd_r <= lib_mem[lib_addr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wd;
    end
    map_rd_r <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (mbr_we) begin
      mbr_mem[mbr_addr] <= mbr_wd;
    end
    mbr_rd_r <= mbr_mem[mbr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= 1'b0;
      lcount_r    <= '0;
      mcount_r    <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      color_r     <= color_nxt;
      lcount_r    <= lcount_nxt;
      mcount_r    <= mcount_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    pt_r   <= pt_nxt;
    cin_r  <= cin_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/ipsm_ctrl.sv
// Controller: sequences the reset sweep and the memory steps of each operation.
module ipsm_ctrl
  import ipsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ipsm_sts_t sts,
  output ipsm_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_SWEEP = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_EXEC  = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_SLOT  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_MOVE  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } ipsm_state_t;

  ipsm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: if (sts.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.op_lib) begin
          state_nxt = ST_SLOT;
        end else if (sts.op_read) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_READ:  state_nxt = ST_OUT;
      ST_SLOT:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.erase_move ? ST_MOVE : ST_OUT;
      ST_MOVE:  state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = state_r != ST_IDLE;
  assign cmd.sweep   = state_r == ST_SWEEP;
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.exec    = state_r == ST_EXEC;
  assign cmd.read    = state_r == ST_READ;
  assign cmd.slot    = state_r == ST_SLOT;
  assign cmd.check   = state_r == ST_CHECK;
  assign cmd.move    = state_r == ST_MOVE;
  assign cmd.load    = state_r == ST_OUT;

endmodule

>>> hw/rtl/indexed_point_set_with_members_unit.sv
// Top level of the group tracker: member list, liberty sparse set and group colour.
//
// One group of points: a colour, an append-only member list and a liberty set kept as a
// dense list plus a per-point slot map, so add, membership and swap-with-last erase are
// constant time. Each input beat carries one operation and yields exactly one result beat.
// A map entry is trusted only when its slot lies below the liberty count and the dense list
// holds the same point there, so clear and start empty the set just by zeroing the counts.
// After reset the block sweeps the slot map to zero, one entry a cycle; in_stall stays
// high during the sweep. Items are handled one at a time: the accept step, an execute
// step, a read step for the two reads or slot and check steps for the liberty ops, a
// move step for an erase that must move the tail entry, and an output step that loads
// the output register. The erase sequence is set by the single port of the liberty list: an
// erase reads the slot map, then the list at the slot, then the tail entry, and then
// writes the tail into the freed slot and its new slot into the map. The next item is
// accepted while a finished result waits on out_stall; it holds only at its own output
// step until the output register frees. Full lists flag overflow and leave state as is.
module indexed_point_set_with_members_unit
  import ipsm_pkg::*;
#(
  parameter int NUM_POINTS    = 512,
  parameter int MAX_LIBERTIES = 256,
  parameter int MAX_MEMBERS   = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ipsm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ipsm_out_t out_data
);

  ipsm_cmd_t cmd;
  ipsm_sts_t sts;

  // sequence each beat through the memory steps
  ipsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the group state, memories and the output register
  ipsm_datapath #(
    .NUM_POINTS    (NUM_POINTS),
    .MAX_LIBERTIES (MAX_LIBERTIES),
    .MAX_MEMBERS   (MAX_MEMBERS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
